// ===== hw/rtl/owd_pkg.sv =====
// owd_pkg: shared types and constants of the oscillation window detector
// no dependencies; imported by owd_ctrl, owd_dp, oscillation_window_detector and tb
package owd_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int THRESH_W  = 15;
    localparam int WINDOW_W  = 32;
    localparam int MAXCHG_W  = 5;
    localparam int CONSEC_W  = 8;
    localparam int ERR_W     = 16;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [THRESH_W-1:0] THRESH_RST = 15'd100;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 32'd5000;
    localparam logic [MAXCHG_W-1:0] MAXCHG_RST = 5'd4;
    localparam logic [CONSEC_W-1:0] CONSEC_RST = 8'd3;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_WINDOW = 2'd1,
        REG_MAXCHG = 2'd2,
        REG_CONSEC = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [THRESH_W-1:0] magnitude_threshold;
        logic [WINDOW_W-1:0] window_ms;
        logic [MAXCHG_W-1:0] change_limit;
        logic [CONSEC_W-1:0] consec_threshold;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic clear;
        logic pop;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic expire;
    } dp_status_t;

endpackage

// ===== hw/rtl/oscillation_window_detector.sv =====
// oscillation_window_detector: top level with stream ports, apb register file,
// controller and datapath; depends on owd_pkg, owd_ctrl and owd_dp
// states: clear request idle, result; sample request idle, read, check, update, result
// one request in flight; the next is accepted in the cycle after the result is registered
// expiry loop (read, check per expired entry) sets the rate: each pop waits one registered read
// reset: rst_n async low; detector state cleared, registers to defaults, ring contents undefined
module oscillation_window_detector #(
    parameter int RING_DEPTH = owd_pkg::RING_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [owd_pkg::IN_DATA_W-1:0]     s_tdata,   // error_sample[15:0], now_ms[47:16]
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [owd_pkg::OUT_DATA_W-1:0]    m_tdata,   // oscillating[0], change_count[5:1], zero
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [owd_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import owd_pkg::*;

    cfg_t                cfg_reg;
    dp_cmd_t             cmd;
    dp_status_t          status;
    logic                out_osc;
    logic [COUNT_W-1:0]  out_count;
    logic                wr_en;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magnitude_threshold <= THRESH_RST;
            cfg_reg.window_ms           <= WINDOW_RST;
            cfg_reg.change_limit        <= MAXCHG_RST;
            cfg_reg.consec_threshold    <= CONSEC_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESH: cfg_reg.magnitude_threshold <= pwdata[THRESH_W-1:0];
                REG_WINDOW: cfg_reg.window_ms           <= pwdata[WINDOW_W-1:0];
                REG_MAXCHG: cfg_reg.change_limit        <= pwdata[MAXCHG_W-1:0];
                REG_CONSEC: cfg_reg.consec_threshold    <= pwdata[CONSEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESH: prdata = 32'(cfg_reg.magnitude_threshold);
            REG_WINDOW: prdata = cfg_reg.window_ms;
            REG_MAXCHG: prdata = 32'(cfg_reg.change_limit);
            REG_CONSEC: prdata = 32'(cfg_reg.consec_threshold);
            default:    prdata = '0;
        endcase
    end

    owd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    owd_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_error        (s_tdata[ERR_W-1:0]),
        .in_now          (s_tdata[ERR_W +: TIME_W]),
        .cmd             (cmd),
        .status          (status),
        .out_oscillating (out_osc),
        .out_count       (out_count)
    );

    assign m_tdata = {(OUT_DATA_W - COUNT_W - 1)'(0), out_count, out_osc};

endmodule

// ===== hw/rtl/owd_ctrl.sv =====
// owd_ctrl: request sequencing state machine of the detector
// depends on owd_pkg; drives owd_dp through dp_cmd_t and reads dp_status_t
module owd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output owd_pkg::dp_cmd_t    cmd,
    input  owd_pkg::dp_status_t status
);
    import owd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_UPDATE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    cmd.clear   = s_tuser;
                    state_next  = s_tuser ? S_RESULT : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.expire)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request accepted but controller stayed idle");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ))
        else $error("expiry check without a ring read");

    a_result_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result shown outside result state");

endmodule

// ===== hw/rtl/owd_dp.sv =====
// owd_dp: datapath with input latch, sign tracking, timestamp ring memory and result register
// depends on owd_pkg; commanded by owd_ctrl
module owd_dp #(
    parameter int RING_DEPTH = owd_pkg::RING_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  owd_pkg::cfg_t                cfg,
    input  logic [owd_pkg::ERR_W-1:0]    in_error,
    input  logic [owd_pkg::TIME_W-1:0]   in_now,
    input  owd_pkg::dp_cmd_t             cmd,
    output owd_pkg::dp_status_t          status,
    output logic                         out_oscillating,
    output logic [owd_pkg::COUNT_W-1:0]  out_count
);
    import owd_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    logic signed [ERR_W-1:0]  err_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [TIME_W-1:0]        rd_data_reg;
    logic [TIME_W-1:0]        ring_mem [RING_DEPTH];

    sign_t                    sign_reg, sign_next;
    logic [CONSEC_W-1:0]      run_reg, run_next;
    logic [IDX_W-1:0]         oldest_reg, oldest_next;
    logic [IDX_W-1:0]         next_reg, next_next;
    logic [CNT_W-1:0]         live_reg, live_next;
    logic                     osc_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic [TIME_W-1:0]        age;
    logic [ERR_W-1:0]         mag;
    logic                     is_pos, is_neg, qualify, same_sign, record;
    sign_t                    sign_init;
    logic                     ring_full;
    logic [CMP_W-1:0]         live_ext;
    logic [CMP_W-1:0]         max_ext;

    function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx);
        ring_adv = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // expiry age, modulo 2^32
    assign age           = now_reg - rd_data_reg;
    assign status.expire = (live_reg != '0) && (age > cfg.window_ms);

    assign is_neg  = err_reg[ERR_W-1];
    assign is_pos  = !is_neg && (err_reg != '0);
    assign mag     = is_neg ? (~err_reg + 1'b1) : err_reg;
    assign qualify = mag >= {1'b0, cfg.magnitude_threshold};

    assign sign_init = (sign_reg == SIGN_NONE) ? (is_pos ? SIGN_POS : SIGN_NEG) : sign_reg;
    assign same_sign = (is_pos && sign_init == SIGN_POS) || (is_neg && sign_init == SIGN_NEG);
    assign record    = cmd.update && qualify && !same_sign
                       && (run_reg == cfg.consec_threshold - 1'b1);
    assign ring_full = (live_reg == CNT_W'(RING_DEPTH));

    always_comb
    begin
        sign_next   = sign_reg;
        run_next    = run_reg;
        oldest_next = oldest_reg;
        next_next   = next_reg;
        live_next   = live_reg;
        priority if (cmd.clear)
        begin
            sign_next   = SIGN_NONE;
            run_next    = '0;
            oldest_next = '0;
            next_next   = '0;
            live_next   = '0;
        end
        else if (cmd.pop)
        begin
            oldest_next = ring_adv(oldest_reg);
            live_next   = live_reg - 1'b1;
        end
        else if (cmd.update && qualify)
        begin
            sign_next = sign_init;
            if (same_sign)
            begin
                run_next = '0;
            end
            else if (record)
            begin
                sign_next = is_pos ? SIGN_POS : SIGN_NEG;
                run_next  = '0;
                next_next = ring_adv(next_reg);
                // full ring drops its oldest entry
                if (ring_full)
                begin
                    oldest_next = ring_adv(oldest_reg);
                end
                else
                begin
                    live_next = live_reg + 1'b1;
                end
            end
            else
            begin
                run_next = run_reg + 1'b1;
            end
        end
        else
        begin
            // hold
        end
    end

    assign live_ext = CMP_W'(live_reg);
    assign max_ext  = CMP_W'(cfg.change_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg   <= SIGN_NONE;
            run_reg    <= '0;
            oldest_reg <= '0;
            next_reg   <= '0;
            live_reg   <= '0;
        end
        else
        begin
            sign_reg   <= sign_next;
            run_reg    <= run_next;
            oldest_reg <= oldest_next;
            next_reg   <= next_next;
            live_reg   <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg <= in_error;
            now_reg <= in_now;
        end
        if (cmd.load_out)
        begin
            osc_reg   <= live_ext >= max_ext;
            count_reg <= (live_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX : live_ext[COUNT_W-1:0];
        end
    end

    // timestamp ring
    always_ff @(posedge clk)
    begin
        if (record)
        begin
            ring_mem[next_reg] <= now_reg;
        end
        rd_data_reg <= ring_mem[oldest_reg];
    end

    assign out_oscillating = osc_reg;
    assign out_count       = count_reg;

    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(RING_DEPTH))
        else $error("live change count exceeds ring depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (live_reg != '0))
        else $error("expiry pop on empty ring");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (live_reg == '0) && (oldest_reg == next_reg))
        else $error("clear left ring entries");

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for oscillation_window_detector, stream and apb stimulus
// with a built-in sign-change predictor, random idling on both stream sides
// depends on owd_pkg and the oscillation_window_detector rtl
module tb;

    import owd_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef struct {
        logic                    clear;
        logic signed [ERR_W-1:0] err;
        logic [TIME_W-1:0]       now;
    } sample_t;

    typedef struct {
        logic               osc;
        logic [COUNT_W-1:0] cnt;
    } verdict_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    cfg_t              cfg_m;
    sign_t             sgn;
    logic [7:0]        opp_run;
    logic [TIME_W-1:0] ring_stamp [DEPTH];
    int                ring_head;
    int                ring_tail;
    int                live;

    sample_t  sample_q [$];
    verdict_t verdict_q [$];
    sample_t  tx_item;
    verdict_t want;
    int       send_gap;
    int       sink_gap;
    int       errors = 0;
    bit       idle_on = 1'b1;
    logic [TIME_W-1:0] clock_ms = '0;

    oscillation_window_detector DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic verdict_t detector_step(input sample_t s);
        verdict_t v;
        int       e;
        int       m;
        if (s.clear)
        begin
            sgn       = SIGN_NONE;
            opp_run   = '0;
            ring_head = 0;
            ring_tail = 0;
            live      = 0;
        end
        else
        begin
            // expire stale sign changes, oldest first
            while (live > 0 && (s.now - ring_stamp[ring_head]) > cfg_m.window_ms)
            begin
                ring_head = (ring_head + 1) % DEPTH;
                live--;
            end
            e = s.err;
            m = (e < 0) ? -e : e;
            if (m >= int'(cfg_m.magnitude_threshold))
            begin
                if (sgn == SIGN_NONE)
                    sgn = (e > 0) ? SIGN_POS : SIGN_NEG;
                if ((e > 0 && sgn == SIGN_POS) || (e < 0 && sgn == SIGN_NEG))
                    opp_run = '0;
                else if (opp_run == 8'(cfg_m.consec_threshold - 8'd1))
                begin
                    sgn     = (e > 0) ? SIGN_POS : SIGN_NEG;
                    opp_run = '0;
                    if (live >= DEPTH)
                    begin
                        ring_head = (ring_head + 1) % DEPTH;
                        live--;
                    end
                    ring_stamp[ring_tail] = s.now;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    live++;
                end
                else
                    opp_run = opp_run + 8'd1;
            end
        end
        v.osc = (live >= int'(cfg_m.change_limit));
        v.cnt = (live > 31) ? 5'd31 : 5'(live);
        return v;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(detector_step(tx_item));
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    tx_item = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_item.now, tx_item.err};
                    s_tuser  <= tx_item.clear;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.osc)
                    begin
                        $display("%0t: oscillating expected %0d actual %0d",
                                 $time, want.osc, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[5:1] !== want.cnt)
                    begin
                        $display("%0t: change_count expected %0d actual %0d",
                                 $time, want.cnt, m_tdata[5:1]);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    task automatic queue_request(input logic clr, input int err, input logic [TIME_W-1:0] now);
        sample_t it;
        it.clear = clr;
        it.err   = 16'(err);
        it.now   = now;
        sample_q.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sample_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESH: cfg_m.magnitude_threshold = val[THRESH_W-1:0];
            REG_WINDOW: cfg_m.window_ms           = val[WINDOW_W-1:0];
            REG_MAXCHG: cfg_m.change_limit        = val[MAXCHG_W-1:0];
            REG_CONSEC: cfg_m.consec_threshold    = val[CONSEC_W-1:0];
            default: ;
        endcase
    endtask

    // runs of same-sign samples sized around the consecutive threshold
    task automatic run_phase(input logic [THRESH_W-1:0] thr, input logic [WINDOW_W-1:0] win,
                             input logic [MAXCHG_W-1:0] maxc, input logic [CONSEC_W-1:0] cons,
                             input int count, input int step_max, input int clear_pct,
                             input bit idles);
        sample_t it;
        int      eff;
        int      run_len;
        int      n;
        int      k;
        int      r;
        int      m;
        bit      neg;
        wait_drained();
        repeat (2) @(posedge clk);
        idle_on = idles;
        reg_write(REG_THRESH, {17'd0, thr});
        reg_write(REG_WINDOW, win);
        reg_write(REG_MAXCHG, {27'd0, maxc});
        reg_write(REG_CONSEC, {24'd0, cons});
        eff = (cons == 0) ? 256 : int'(cons);
        neg = $urandom_range(0, 1);
        n   = 0;
        while (n < count)
        begin
            if (n == 0)
                run_len = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 70)
                run_len = $urandom_range((eff > 1) ? eff - 1 : 1, eff + 1);
            else
                run_len = $urandom_range(1, eff);
            if ($urandom_range(0, 99) < 80)
                neg = !neg;
            for (k = 0; k < run_len && n < count; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    clock_ms -= $urandom_range(1, 50);
                else if (r < 5)
                    clock_ms += win + $urandom_range(0, 2);
                else
                    clock_ms += $urandom_range(0, step_max);
                it.now   = clock_ms;
                it.clear = 1'b0;
                r = $urandom_range(0, 99);
                if (r < clear_pct)
                begin
                    it.clear = 1'b1;
                    it.err   = 16'($urandom);
                end
                else if (r < 8 + clear_pct && thr > 0)
                begin
                    m = $urandom_range(0, thr - 1);
                    it.err = 16'($urandom_range(0, 1) ? -m : m);
                end
                else
                begin
                    if (r < 20)
                        m = neg ? 32768 : 32767;
                    else if (r < 26)
                        m = thr;
                    else
                        m = $urandom_range(thr, neg ? 32768 : 32767);
                    it.err = 16'(neg ? -m : m);
                end
                sample_q.push_back(it);
                n++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        logic [THRESH_W-1:0] thr;
        logic [WINDOW_W-1:0] win;
        logic [CONSEC_W-1:0] cons;
        int                  p;
        cfg_m.magnitude_threshold = THRESH_RST;
        cfg_m.window_ms           = WINDOW_RST;
        cfg_m.change_limit        = MAXCHG_RST;
        cfg_m.consec_threshold    = CONSEC_RST;
        sgn       = SIGN_NONE;
        opp_run   = '0;
        ring_head = 0;
        ring_tail = 0;
        live      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at reset register values
        queue_request(1'b1, 0, 32'd0);
        queue_request(1'b0, 32767, 32'd0);
        queue_request(1'b0, 99, 32'd10);
        queue_request(1'b0, -99, 32'd10);
        queue_request(1'b0, 0, 32'd10);
        queue_request(1'b0, -100, 32'd20);
        queue_request(1'b0, -32768, 32'd30);
        queue_request(1'b0, -101, 32'd40);
        queue_request(1'b0, -5000, 32'd50);
        queue_request(1'b0, 100, 32'd60);
        queue_request(1'b0, -200, 32'd70);
        queue_request(1'b0, 300, 32'd80);
        queue_request(1'b0, 400, 32'd90);
        queue_request(1'b0, 500, 32'd100);
        queue_request(1'b0, -300, 32'd110);
        queue_request(1'b0, -300, 32'd120);
        queue_request(1'b0, -300, 32'd130);
        queue_request(1'b0, 300, 32'd140);
        queue_request(1'b0, 300, 32'd150);
        queue_request(1'b0, 32767, 32'd160);
        // age equal to the window keeps the entry, one more expires it
        queue_request(1'b0, 5, 32'd5040);
        queue_request(1'b0, 5, 32'd5041);
        // time running backwards wraps and expires everything
        queue_request(1'b0, 5, 32'd90);
        queue_request(1'b0, -300, 32'hFFFF_FFFF);
        queue_request(1'b1, -32768, 32'hFFFF_FFFF);

        run_phase(15'd100, 32'd5000, 5'd4, 8'd3, 120, 400, 3, 1'b1);
        run_phase(15'd0, 32'h000F_FFFF, 5'd16, 8'd1, 120, 50, 0, 1'b0);
        run_phase(15'd700, 32'd12000, 5'd0, 8'd0, 270, 10, 0, 1'b1);
        run_phase(15'd32767, 32'd0, 5'd1, 8'd255, 270, 1, 0, 1'b1);
        run_phase(15'd1, 32'd100, 5'd31, 8'd2, 80, 15, 3, 1'b1);
        for (p = 0; p < 3; p++)
        begin
            thr  = $urandom_range(0, 3000);
            win  = $urandom_range(0, 30000);
            cons = $urandom_range(1, 8);
            run_phase(thr, win, 5'($urandom_range(0, 31)), cons, 80,
                      int'(win / (cons * 3)) + 1, 3, 1'b1);
        end
        run_phase(15'd50, 32'hFFFF_FFFF, 5'd16, 8'd1, 60, 1000000, 0, 1'b1);

        repeat (40) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("oscillation_window_detector verification clean");
        else
            $display("oscillation_window_detector verification failed");
        $finish;
    end

    initial
    begin
        #18000000;
        $display("oscillation_window_detector verification failed");
        $finish;
    end

endmodule
